// File: src/crpts_pkg.sv
// Shared types and constants of the table sampler.
// Used by the accumulate and compare unit and by the top level; no dependencies.
package crpts_pkg;

  localparam int FRAC_W   = 16;
  localparam int ALPHA_W  = 32;
  localparam int DISC_W   = 16;
  localparam int UNIF_W   = 16;
  localparam int REQ_W    = 2;
  localparam int IDX_W    = 8;
  localparam int TABLE_W  = 9;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W  = 24;
  localparam int IN_W     = 32;
  localparam int OUT_W    = 16;
  localparam int CFG_AW   = 1;

  // Scaled total is 41 bits; times a 16-bit draw gives 57 bits.
  localparam int TOT_W = TOTAL_W + FRAC_W + 1;
  localparam int ACC_W = TOT_W + UNIF_W;
  localparam int THR_W = ACC_W - FRAC_W;

  localparam logic [ALPHA_W-1:0] CONC_RESET = 32'h0001_0000;

  localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ADD    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REMOVE_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE        = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NO_FREE      = 2'd3;

  localparam logic [CFG_AW-1:0] CFG_CONCENTRATION = 1'd0;
  localparam logic [CFG_AW-1:0] CFG_DISCOUNT      = 1'd1;

  typedef struct packed {
    logic             clr;
    logic             en;
    logic [ACC_W-1:0] operand;
  } alu_op_t;

endpackage

// File: src/crpts_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module crpts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/crpts_alu.sv
// Shared accumulate and compare unit: one wide adder used for the threshold
// multiply and for the weight walk. Depends on crpts_pkg.
module crpts_alu (
  input  logic                              clk,
  input  crpts_pkg::alu_op_t                op,
  input  logic [crpts_pkg::THR_W-1:0]       limit,
  output logic [crpts_pkg::ACC_W-1:0]       acc,
  output logic                              hit
);
  import crpts_pkg::*;

  logic [ACC_W-1:0] sum;

  assign sum = acc + op.operand;
  assign hit = ACC_W'(limit) < sum;

  always_ff @(posedge clk) begin
    if (op.clr) begin
      acc <= '0;
    end else if (op.en) begin
      acc <= sum;
    end
  end

endmodule

// File: src/crp_table_sampler_unit.sv
// Top level of the table sampler: sequencer, count store and registers.
// Depends on crpts_pkg, crpts_ram and crpts_alu.
//
// Channel  Direction  Transaction fields
// s_*      in         req_type, table_index, uniform_draw
// m_*      out        chosen_table, is_new_table, status
// cfg_*    in         register index and value, no read-back
//
// A sample runs 16 shift-add steps for the threshold, then walks one table a cycle
// through the count RAM read port; a hit ends the walk early.
// Add and remove go through S_UPD to S_DONE; an out-of-range index or an unused
// code goes straight to S_DONE. After reset the count RAM is cleared one entry
// a cycle, with s_tready low. A new transaction is taken while a result waits
// in the output register; a stalled output holds the next result back.
module crp_table_sampler_unit #(
  parameter int MAX_TABLES = 256,
  parameter int COUNT_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [1:0] req_type, [9:2] table_index, [25:10] uniform_draw
  input  logic [crpts_pkg::IN_W-1:0]        s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [8:0] chosen_table, [9] is_new_table, [11:10] status
  output logic [crpts_pkg::OUT_W-1:0]       m_tdata,
  input  logic                              cfg_we,
  input  logic [crpts_pkg::CFG_AW-1:0]      cfg_addr,
  input  logic [crpts_pkg::ALPHA_W-1:0]     cfg_wdata
);
  import crpts_pkg::*;

  localparam int TIDX_W  = $clog2(MAX_TABLES);
  localparam int FRESH_W = TIDX_W + 1;
  localparam logic [TIDX_W-1:0] LAST_IDX = TIDX_W'(MAX_TABLES - 1);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_MUL   = 7'b0000100,
    S_THR   = 7'b0001000,
    S_WALK  = 7'b0010000,
    S_UPD   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state;

  logic [ALPHA_W-1:0]    concentration;
  logic [DISC_W-1:0]     discount;
  logic [TOTAL_W-1:0]    customer_total;
  logic [FRESH_W-1:0]    fresh_index;

  logic [REQ_W-1:0]      in_req;
  logic [IDX_W-1:0]      in_idx;
  logic [UNIF_W-1:0]     in_unif;
  logic                  in_range_bad;

  logic [REQ_W-1:0]      req;
  logic [IDX_W-1:0]      req_idx;
  logic [TIDX_W:0]       cnt;
  logic                  dv;
  logic [TIDX_W-1:0]     didx;
  logic [ACC_W-1:0]      mcand;
  logic [UNIF_W-1:0]     mplier;
  logic [3:0]            bitcnt;
  logic [THR_W-1:0]      thr;

  logic [TABLE_W-1:0]    res_table;
  logic                  res_new;
  logic [STATUS_W-1:0]   res_status;

  logic                  ram_we;
  logic [TIDX_W-1:0]     ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic [TIDX_W-1:0]     ram_raddr;
  logic [COUNT_BITS-1:0] ram_rdata;

  alu_op_t               alu_op;
  logic [ACC_W-1:0]      alu_acc;
  logic                  alu_hit;
  logic [ACC_W-1:0]      weight;
  logic                  rd_zero;
  logic                  rd_full;
  logic                  tot_full;
  logic [FRESH_W-1:0]    idx_plus1;

  assign in_req       = s_tdata[1:0];
  assign in_idx       = s_tdata[9:2];
  assign in_unif      = s_tdata[25:10];
  assign in_range_bad = 32'(in_idx) >= 32'(MAX_TABLES);

  assign s_tready = (state == S_IDLE);

  assign rd_zero   = (ram_rdata == '0);
  assign rd_full   = (ram_rdata == '1);
  assign tot_full  = (customer_total == '1);
  assign weight    = ACC_W'({ram_rdata, {FRAC_W{1'b0}}}) - ACC_W'(discount);
  assign idx_plus1 = FRESH_W'(32'(req_idx) + 32'd1);

  assign ram_raddr = (state == S_IDLE) ? TIDX_W'(in_idx) : cnt[TIDX_W-1:0];

  crpts_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (MAX_TABLES)
  ) u_count_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  crpts_alu u_alu (
    .clk   (clk),
    .op    (alu_op),
    .limit (thr),
    .acc   (alu_acc),
    .hit   (alu_hit)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = TIDX_W'(req_idx);
    ram_wdata = '0;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt[TIDX_W-1:0];
      end
      S_UPD: begin
        if (req == REQ_ADD) begin
          ram_we    = !(tot_full || rd_full);
          ram_wdata = ram_rdata + 1'b1;
        end else begin
          ram_we    = !rd_zero;
          ram_wdata = ram_rdata - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    alu_op = '0;
    case (state)
      S_IDLE: begin
        alu_op.clr = 1'b1;
      end
      S_MUL: begin
        alu_op.en      = mplier[0];
        alu_op.operand = mcand;
      end
      S_THR: begin
        alu_op.clr = 1'b1;
      end
      S_WALK: begin
        alu_op.en      = dv && !rd_zero;
        alu_op.operand = weight;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      cnt            <= '0;
      dv             <= 1'b0;
      customer_total <= '0;
      fresh_index    <= '0;
      m_tvalid       <= 1'b0;
      concentration  <= CONC_RESET;
      discount       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_CONCENTRATION: concentration <= cfg_wdata;
          CFG_DISCOUNT:      discount      <= cfg_wdata[DISC_W-1:0];
          default: begin
          end
        endcase
      end

      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      dv   <= (state == S_WALK);
      didx <= cnt[TIDX_W-1:0];

      case (state)
        S_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt[TIDX_W-1:0] == LAST_IDX) begin
            cnt   <= '0;
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            req        <= in_req;
            req_idx    <= in_idx;
            res_table  <= TABLE_W'(in_idx);
            res_new    <= 1'b0;
            res_status <= ST_OK;
            case (in_req)
              REQ_SAMPLE: begin
                mcand  <= ACC_W'({customer_total, {FRAC_W{1'b0}}}) + ACC_W'(concentration);
                mplier <= in_unif;
                bitcnt <= '0;
                state  <= S_MUL;
              end
              REQ_ADD, REQ_REMOVE: begin
                if (in_range_bad) begin
                  res_status <= ST_RANGE;
                  state      <= S_DONE;
                end else begin
                  state <= S_UPD;
                end
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_MUL: begin
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          bitcnt <= bitcnt + 1'b1;
          if (bitcnt == '1) begin
            state <= S_THR;
          end
        end
        S_THR: begin
          thr   <= alu_acc[ACC_W-1:FRAC_W];
          cnt   <= '0;
          state <= S_WALK;
        end
        S_WALK: begin
          cnt <= cnt + 1'b1;
          if (alu_op.en && alu_hit) begin
            res_table  <= TABLE_W'(didx);
            res_new    <= 1'b0;
            res_status <= ST_OK;
            state      <= S_DONE;
          end else if (dv && didx == LAST_IDX) begin
            res_table <= TABLE_W'(fresh_index);
            if (32'(fresh_index) >= 32'(MAX_TABLES)) begin
              res_new    <= 1'b0;
              res_status <= ST_NO_FREE;
            end else begin
              res_new    <= 1'b1;
              res_status <= ST_OK;
            end
            state <= S_DONE;
          end
        end
        S_UPD: begin
          if (req == REQ_ADD) begin
            if (!(tot_full || rd_full)) begin
              customer_total <= customer_total + 1'b1;
              if (rd_zero) begin
                res_new <= 1'b1;
                if (fresh_index < idx_plus1) begin
                  fresh_index <= idx_plus1;
                end
              end
            end
          end else begin
            if (rd_zero) begin
              res_status <= ST_REMOVE_EMPTY;
            end else if (customer_total != '0) begin
              customer_total <= customer_total - 1'b1;
            end
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= OUT_W'({res_status, res_new, res_table});
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: sim/crp_table_sampler_unit_tb.sv
`timescale 1ns / 1ps
// Testbench for crp_table_sampler_unit: seats, unseats and samples tables over the stream ports.
// Depends on crpts_pkg and the sampler RTL; a scoreboard class tracks the seating and checks picks.

import crpts_pkg::*;

typedef struct packed {
  logic [STATUS_W-1:0] status;
  logic                is_new;
  logic [TABLE_W-1:0]  table_no;
} pick_t;

class seating_tracker;
  localparam int TABLES = 256;

  logic [15:0]        seat_count [TABLES];
  logic [TOTAL_W-1:0] diners;
  int unsigned        fresh;
  logic [ALPHA_W-1:0] alpha;
  logic [DISC_W-1:0]  disc;
  pick_t              expected_picks [$];
  int                 mismatches;

  function void clear();
    foreach (seat_count[i]) seat_count[i] = '0;
    diners = '0;
    fresh = 0;
    alpha = CONC_RESET;
    disc = '0;
    mismatches = 0;
  endfunction

  function void set_reg(logic [CFG_AW-1:0] addr, logic [ALPHA_W-1:0] value);
    if (addr == CFG_CONCENTRATION) alpha = value;
    else if (addr == CFG_DISCOUNT) disc = value[DISC_W-1:0];
  endfunction

  function void note_request(logic [REQ_W-1:0] req, logic [IDX_W-1:0] idx,
                             logic [UNIF_W-1:0] u);
    pick_t       p;
    logic [63:0] total;
    logic [63:0] thr;
    logic [63:0] sum;
    bit          hit;
    p.table_no = {1'b0, idx};
    p.is_new = 1'b0;
    p.status = ST_OK;
    case (req)
      REQ_SAMPLE: begin
        total = ({40'd0, diners} << 16) + {32'd0, alpha};
        thr = ({48'd0, u} * total) >> 16;
        sum = '0;
        hit = 0;
        for (int i = 0; i < TABLES; i++) begin
          if (!hit && seat_count[i] != 0) begin
            sum = sum + ({48'd0, seat_count[i]} << 16) - {48'd0, disc};
            if (thr < sum) begin
              hit = 1;
              p.table_no = TABLE_W'(i);
            end
          end
        end
        if (!hit) begin
          p.table_no = TABLE_W'(fresh);
          if (fresh >= TABLES) p.status = ST_NO_FREE;
          else p.is_new = 1'b1;
        end
      end
      REQ_ADD: begin
        if (int'(idx) >= TABLES) begin
          p.status = ST_RANGE;
        end else if (diners != {TOTAL_W{1'b1}} && seat_count[idx] != 16'hFFFF) begin
          diners = diners + 1'b1;
          if (seat_count[idx] == 0) begin
            p.is_new = 1'b1;
            if (fresh < int'(idx) + 1) fresh = int'(idx) + 1;
          end
          seat_count[idx] = seat_count[idx] + 1'b1;
        end
      end
      REQ_REMOVE: begin
        if (int'(idx) >= TABLES) begin
          p.status = ST_RANGE;
        end else if (seat_count[idx] == 0) begin
          p.status = ST_REMOVE_EMPTY;
        end else begin
          seat_count[idx] = seat_count[idx] - 1'b1;
          if (diners != 0) diners = diners - 1'b1;
        end
      end
      default: ;
    endcase
    expected_picks = {expected_picks, p};
  endfunction

  function void check_result(logic [OUT_W-1:0] data);
    pick_t got;
    pick_t want;
    got = data[TABLE_W+STATUS_W:0];
    if (expected_picks.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: table %0d new %0d status %0d",
                 got.table_no, got.is_new, got.status);
      return;
    end
    want = expected_picks.pop_front();
    if (got.table_no !== want.table_no || got.is_new !== want.is_new ||
        got.status !== want.status) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result mismatch: table %0d/%0d new %0d/%0d status %0d/%0d (exp/act)",
                 want.table_no, got.table_no, want.is_new, got.is_new,
                 want.status, got.status);
    end
  endfunction
endclass

module crp_table_sampler_unit_tb;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  logic               clk = 1'b0;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  logic [IN_W-1:0]    s_tdata;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [OUT_W-1:0]   m_tdata;
  logic               cfg_we;
  logic [CFG_AW-1:0]  cfg_addr;
  logic [ALPHA_W-1:0] cfg_wdata;

  int             idle_mode;
  seating_tracker tracker;

  crp_table_sampler_unit uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  function automatic int sender_idle_pct();
    case (idle_mode)
      1: return 74;
      3: return 13;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_stall_pct();
    case (idle_mode)
      2: return 74;
      3: return 13;
      default: return 0;
    endcase
  endfunction

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= receiver_stall_pct());
  end

  always @(negedge clk) begin
    if (!rst && m_tvalid === 1'b1 && m_tready) tracker.check_result(m_tdata);
  end

  task automatic send_request(input logic [REQ_W-1:0] req, input logic [IDX_W-1:0] idx,
                              input logic [UNIF_W-1:0] u);
    bit taken;
    while ($urandom_range(99) < sender_idle_pct()) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'd0, u, idx, req};
    taken = 0;
    while (!taken) begin
      @(negedge clk);
      taken = s_tready;
      @(posedge clk);
    end
    tracker.note_request(req, idx, u);
  endtask

  task automatic wait_results_done();
    s_tvalid <= 1'b0;
    while (tracker.expected_picks.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [ALPHA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    tracker.set_reg(addr, value);
  endtask

  task automatic random_request(input bit full_range);
    int                pick;
    int                top;
    logic [REQ_W-1:0]  req;
    logic [IDX_W-1:0]  idx;
    logic [UNIF_W-1:0] u;
    top = full_range ? 255 : 254;
    pick = $urandom_range(99);
    if (pick < 40) req = REQ_ADD;
    else if (pick < 65) req = REQ_REMOVE;
    else if (pick < 95) req = REQ_SAMPLE;
    else req = REQ_UNUSED;
    pick = $urandom_range(99);
    if (pick < 65) idx = IDX_W'($urandom_range(15));
    else if (pick < 90) idx = IDX_W'($urandom_range(top));
    else idx = $urandom_range(1) ? IDX_W'(top) : '0;
    pick = $urandom_range(99);
    if (pick < 80) u = UNIF_W'($urandom);
    else u = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    send_request(req, idx, u);
  endtask

  task automatic run_phase(input int mode, input int count, input bit full_range);
    idle_mode = mode;
    repeat (count) random_request(full_range);
    wait_results_done();
  endtask

  initial begin
    tracker = new;
    tracker.clear();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    idle_mode = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_request(REQ_SAMPLE, 8'h00, 16'h0000);
    send_request(REQ_SAMPLE, 8'h5A, 16'hFFFF);
    send_request(REQ_ADD, 8'h00, 16'h0000);
    send_request(REQ_ADD, 8'h00, 16'hFFFF);
    send_request(REQ_SAMPLE, 8'h00, 16'h0000);
    send_request(REQ_SAMPLE, 8'h00, 16'hFFFF);
    send_request(REQ_REMOVE, 8'h00, 16'h0000);
    send_request(REQ_REMOVE, 8'h00, 16'h0000);
    send_request(REQ_REMOVE, 8'h00, 16'h0000);
    send_request(REQ_REMOVE, 8'hFF, 16'h0000);
    send_request(REQ_UNUSED, 8'hFF, 16'hFFFF);
    send_request(REQ_UNUSED, 8'h00, 16'h0000);
    send_request(REQ_ADD, 8'd200, 16'h1234);
    send_request(REQ_ADD, 8'd3, 16'h0000);
    send_request(REQ_SAMPLE, 8'h00, 16'h8000);
    send_request(REQ_REMOVE, 8'd200, 16'h0000);
    send_request(REQ_SAMPLE, 8'hAA, 16'h7FFF);
    send_request(REQ_ADD, 8'd254, 16'h0000);
    send_request(REQ_SAMPLE, 8'h55, 16'hFFFF);
    send_request(REQ_REMOVE, 8'd254, 16'h0000);
    wait_results_done();

    run_phase(0, 110, 0);

    write_reg(CFG_CONCENTRATION, 32'hFFFF_FFFF);
    write_reg(CFG_DISCOUNT, 32'h0000_0000);
    run_phase(1, 110, 0);

    write_reg(CFG_CONCENTRATION, 32'h0000_0001);
    write_reg(CFG_DISCOUNT, 32'h0000_FFFF);
    run_phase(2, 110, 1);

    write_reg(CFG_CONCENTRATION, 32'h0000_0000);
    write_reg(CFG_DISCOUNT, 32'h0000_8000);
    run_phase(3, 110, 1);

    write_reg(CFG_CONCENTRATION, $urandom | 32'h8000_0000);
    write_reg(CFG_DISCOUNT, {16'd0, 16'($urandom)});
    idle_mode = 0;
    send_request(REQ_ADD, 8'd255, 16'h0000);
    run_phase(0, 110, 1);

    send_request(REQ_SAMPLE, 8'h00, 16'hFFFF);
    send_request(REQ_SAMPLE, 8'h00, 16'h0001);
    send_request(REQ_REMOVE, 8'd7, 16'h0000);
    send_request(REQ_ADD, 8'd7, 16'h0000);
    send_request(REQ_ADD, 8'd7, 16'h0000);
    send_request(REQ_SAMPLE, 8'h00, 16'($urandom));
    wait_results_done();
    repeat (300) @(posedge clk);

    if (tracker.mismatches == 0 && tracker.expected_picks.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
